@@ design/mcml_pkg.sv @@
// Shared types, codes and defaults for the maze cell merge labeller.
package mcml_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [6:0] GRID_COLUMNS_RST   = 7'd32;
  localparam logic [6:0] GRID_ROWS_RST      = 7'd32;
  localparam logic [3:0] CORRIDOR_WIDTH_RST = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS   = 2'd0,
    CFG_GRID_ROWS      = 2'd1,
    CFG_CORRIDOR_WIDTH = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_CONNECT = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XN = 2'd1,
    DIR_YP = 2'd2,
    DIR_YN = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_MERGED    = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_JOINED    = 3'd2,
    ST_DONE      = 3'd3,
    ST_RESTARTED = 3'd4
  } status_e;

  typedef struct packed {
    logic       operation;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [1:0] direction;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [10:0] wall_x;
    logic [10:0] wall_y;
    logic        run_along_y;
    logic [12:0] cells_in_other_groups;
    logic        all_connected;
  } out_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_RD_SRC,
    S_RD_NB,
    S_CMP,
    S_SCAN,
    S_FILL,
    S_REPORT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic check;
    logic read_src;
    logic read_nb;
    logic compare;
    logic scan;
    logic fill;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_restart;
    logic maze_done;
    logic outside;
    logic joined;
    logic scan_last;
    logic fill_last;
  } dp_stat_t;

endpackage

@@ design/mcml_ctrl.sv @@
// Sequencer for the labeller: clearing pass, lookups, relabel scan and report.
module mcml_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mcml_pkg::dp_stat_t stat_i,
  output mcml_pkg::ctrl_cmd_t cmd_o
);
  import mcml_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (stat_i.fill_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = stat_i.start_restart ? S_FILL : S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.maze_done || stat_i.outside) state_d = S_REPORT;
        else state_d = S_RD_SRC;
      end
      S_RD_SRC: state_d = S_RD_NB;
      S_RD_NB:  state_d = S_CMP;
      S_CMP: begin
        state_d = stat_i.joined ? S_REPORT : S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_last) state_d = S_REPORT;
      end
      S_FILL: begin
        if (stat_i.fill_last) state_d = S_REPORT;
      end
      S_REPORT: state_d = S_IDLE;
      default:  state_d = S_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_INIT:   cmd_o.fill = 1'b1;
      S_IDLE: begin
        busy            = 1'b0;
        cmd_o.load_item = start;
      end
      S_CHECK:  cmd_o.check    = 1'b1;
      S_RD_SRC: cmd_o.read_src = 1'b1;
      S_RD_NB:  cmd_o.read_nb  = 1'b1;
      S_CMP:    cmd_o.compare  = 1'b1;
      S_SCAN:   cmd_o.scan     = 1'b1;
      S_FILL:   cmd_o.fill     = 1'b1;
      S_REPORT: cmd_o.report   = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

@@ design/mcml_dp.sv @@
// Datapath: configuration, label store, address and wall arithmetic, result word.
module mcml_dp #(
  parameter int MAX_COLUMNS = mcml_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = mcml_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcml_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcml_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  mcml_pkg::in_t                   in_i,
  input  mcml_pkg::ctrl_cmd_t             cmd_i,
  output mcml_pkg::dp_stat_t              stat_o,
  output logic                            result_valid_o,
  output mcml_pkg::out_t                  result_o
);
  import mcml_pkg::*;

  localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int OW    = (CNT_W > 13) ? CNT_W : 13;
  localparam int CW    = $clog2(MAX_COLUMNS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int GW    = (CW > RW) ? CW : RW;
  localparam int EW    = ((GW > 6) ? GW : 6) + 1;
  localparam int PW    = 2 * EW;

  localparam logic [EW-1:0] MAX_COLS_E = EW'(MAX_COLUMNS);
  localparam logic [EW-1:0] MAX_ROWS_E = EW'(MAX_ROWS);
  localparam logic [EW-1:0] TWO_E      = EW'(2);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);

  // configuration
  logic [6:0] grid_columns_q, grid_rows_q;
  logic [3:0] corridor_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q   <= GRID_COLUMNS_RST;
      grid_rows_q      <= GRID_ROWS_RST;
      corridor_width_q <= CORRIDOR_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_COLUMNS:   grid_columns_q   <= cfg_data_i;
        CFG_GRID_ROWS:      grid_rows_q      <= cfg_data_i;
        CFG_CORRIDOR_WIDTH: corridor_width_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] cols_raw, rows_raw, cols_w, rows_w;
  logic [3:0]    cw_eff;
  logic [4:0]    pitch;

  always_comb begin
    cols_raw = EW'(grid_columns_q);
    rows_raw = EW'(grid_rows_q);
    if (cols_raw < TWO_E) cols_w = TWO_E;
    else if (cols_raw > MAX_COLS_E) cols_w = MAX_COLS_E;
    else cols_w = cols_raw;
    if (rows_raw < TWO_E) rows_w = TWO_E;
    else if (rows_raw > MAX_ROWS_E) rows_w = MAX_ROWS_E;
    else rows_w = rows_raw;
    cw_eff = (corridor_width_q == 4'd0) ? 4'd1 : corridor_width_q;
    pitch  = {1'b0, cw_eff} + 5'd1;
  end

  // item held for the whole operation
  in_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_i;
  end

  logic [EW-1:0] sx_w, sy_w, nx_w, ny_w;
  logic          outside;

  always_comb begin
    sx_w    = EW'(item_q.cell_x);
    sy_w    = EW'(item_q.cell_y);
    nx_w    = sx_w;
    ny_w    = sy_w;
    outside = (sx_w >= cols_w) || (sy_w >= rows_w);
    case (dir_e'(item_q.direction))
      DIR_XP: begin
        if (sx_w + EW'(1) >= cols_w) outside = 1'b1;
        else nx_w = sx_w + EW'(1);
      end
      DIR_XN: begin
        if (sx_w == '0) outside = 1'b1;
        else nx_w = sx_w - EW'(1);
      end
      DIR_YP: begin
        if (sy_w + EW'(1) >= rows_w) outside = 1'b1;
        else ny_w = sy_w + EW'(1);
      end
      default: begin
        if (sy_w == '0) outside = 1'b1;
        else ny_w = sy_w - EW'(1);
      end
    endcase
  end

  // address and wall arithmetic, registered at the check step
  logic [PW-1:0] src_prod, nb_prod, total_prod;
  logic [11:0]   tx, ty;
  logic [11:0]   wx_c, wy_c;
  logic          along_c;

  always_comb begin
    src_prod   = PW'(sx_w) * PW'(rows_w) + PW'(sy_w);
    nb_prod    = PW'(nx_w) * PW'(rows_w) + PW'(ny_w);
    total_prod = PW'(cols_w) * PW'(rows_w) - PW'(1);
    tx = 12'd1 + 12'(item_q.cell_x) * 12'(pitch);
    ty = 12'd1 + 12'(item_q.cell_y) * 12'(pitch);
    case (dir_e'(item_q.direction))
      DIR_XP: begin
        wx_c = tx + 12'(cw_eff);
        wy_c = ty;
        along_c = 1'b1;
      end
      DIR_XN: begin
        wx_c = tx - 12'd1;
        wy_c = ty;
        along_c = 1'b1;
      end
      DIR_YP: begin
        wx_c = tx;
        wy_c = ty + 12'(cw_eff);
        along_c = 1'b0;
      end
      default: begin
        wx_c = tx;
        wy_c = ty - 12'd1;
        along_c = 1'b0;
      end
    endcase
  end

  logic [AW-1:0] src_addr_q, nb_addr_q, total_m1_q;
  logic [10:0]   wall_x_q, wall_y_q;
  logic          along_y_q, outside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      src_addr_q <= src_prod[AW-1:0];
      nb_addr_q  <= nb_prod[AW-1:0];
      total_m1_q <= total_prod[AW-1:0];
      wall_x_q   <= wx_c[10:0];
      wall_y_q   <= wy_c[10:0];
      along_y_q  <= along_c;
      outside_q  <= outside;
    end
  end

  // label store
  logic [AW-1:0] mem [CELLS];
  logic [AW-1:0] rd_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_ra, mem_wa, mem_wd;

  logic [AW-1:0] cur_q, old_q, chk_q, fill_q;
  logic [OW-1:0] others_q;
  logic          joined_q, done_q;

  always_comb begin
    mem_re = 1'b0;
    mem_ra = chk_q + AW'(1);
    mem_we = 1'b0;
    mem_wa = chk_q;
    mem_wd = cur_q;
    if (cmd_i.read_src) begin
      mem_re = 1'b1;
      mem_ra = src_addr_q;
    end else if (cmd_i.read_nb) begin
      mem_re = 1'b1;
      mem_ra = nb_addr_q;
    end else if (cmd_i.compare) begin
      mem_re = 1'b1;
      mem_ra = '0;
    end else if (cmd_i.scan) begin
      mem_re = 1'b1;
      mem_we = (rd_q == old_q);
    end else if (cmd_i.fill) begin
      mem_we = 1'b1;
      mem_wa = fill_q;
      mem_wd = fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // lookups and relabel scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_nb) cur_q <= rd_q;
    if (cmd_i.compare) begin
      old_q    <= rd_q;
      joined_q <= (rd_q == cur_q);
      chk_q    <= '0;
      others_q <= '0;
    end
    if (cmd_i.scan) begin
      chk_q <= chk_q + AW'(1);
      if (rd_q != old_q && rd_q != cur_q) others_q <= others_q + OW'(1);
    end
  end

  logic merged;
  assign merged = (item_q.operation == OP_CONNECT) && !done_q && !outside_q && !joined_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cmd_i.fill) begin
        fill_q <= (fill_q == LAST_CELL) ? '0 : fill_q + AW'(1);
        done_q <= 1'b0;
      end
      if (cmd_i.report && merged && others_q == '0) done_q <= 1'b1;
    end
  end

  // result word, shown for one cycle after the report step
  out_t result_q, result_d;
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.report;
    end
  end

  always_comb begin
    result_d = '0;
    if (item_q.operation == OP_RESTART) begin
      result_d.status = ST_RESTARTED;
    end else if (done_q) begin
      result_d.status        = ST_DONE;
      result_d.all_connected = 1'b1;
    end else if (outside_q) begin
      result_d.status = ST_OUTSIDE;
    end else if (joined_q) begin
      result_d.status = ST_JOINED;
    end else begin
      result_d.status                = ST_MERGED;
      result_d.wall_x                = wall_x_q;
      result_d.wall_y                = wall_y_q;
      result_d.run_along_y           = along_y_q;
      result_d.cells_in_other_groups = others_q[12:0];
      result_d.all_connected         = (others_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  always_comb begin
    stat_o               = '0;
    stat_o.start_restart = (in_i.operation == OP_RESTART);
    stat_o.maze_done     = done_q;
    stat_o.outside       = outside;
    stat_o.joined        = (rd_q == cur_q);
    stat_o.scan_last     = (chk_q == total_m1_q);
    stat_o.fill_last     = (fill_q == LAST_CELL);
  end

endmodule

@@ design/maze_cell_merge_labeler.sv @@
// Top level of the maze cell merge labeller.
//
// Keeps one group label per room cell (cell x, y at store entry x * rows + y)
// and merges groups on connect words, as in randomised Kruskal maze building.
// Input: a word is taken at a clock edge with start high and busy low.
// Output: each word gives exactly one result word, shown for one cycle with
// result_valid_o high; the receiver cannot hold it off. busy is low in the
// result cycle, so the next word may be started then.
// Configuration: cfg_we_i / cfg_index_i / cfg_data_i, written while idle.
// Steps from accept to result strobe, each followed by the report step:
//   rejected as done or outside the grid: check
//   already joined: check, source read, neighbour read, compare
//   merged: as joined, then a relabel scan over columns * rows labels, with one
//   label read in each cycle and the one before it written if it held the neighbour's label
//   restart: a fill pass over all MAX_COLUMNS * MAX_ROWS labels, rewriting every label
// After reset a clearing pass over all MAX_COLUMNS * MAX_ROWS cells loads fresh
// labels; busy stays high and no word is taken until it ends. Configuration
// writes are taken at any time, including during that pass.
module maze_cell_merge_labeler #(
  parameter int MAX_COLUMNS = mcml_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = mcml_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mcml_pkg::in_t                   in_i,
  output logic                            result_valid_o,
  output mcml_pkg::out_t                  result_o,
  input  logic                            cfg_we_i,
  input  logic [mcml_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mcml_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mcml_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  mcml_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  mcml_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ design/mcml_checker.sv @@
// Port-level checks for the labeller and their binding to the top level.
module mcml_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           busy,
  input logic           result_valid_o,
  input mcml_pkg::out_t result_o
);
  import mcml_pkg::*;

  // result shows only once the work is over
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result word shown while busy");

  // every result follows a busy stretch
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result word without preceding work");

  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == ST_DONE |-> result_o.all_connected)
    else $error("maze done reply without connected flag");

  // rejects and restarts carry no wall or count
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status != ST_MERGED |->
      result_o.wall_x == '0 && result_o.wall_y == '0 &&
      !result_o.run_along_y && result_o.cells_in_other_groups == '0)
    else $error("non-merge reply carries wall or count");

  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.status == ST_RESTARTED |-> !result_o.all_connected)
    else $error("restart reply with connected flag set");

endmodule

bind maze_cell_merge_labeler mcml_checker u_mcml_checker (.*);

@@ sim/tb_maze_cell_merge_labeler.sv @@
// Self-checking testbench for the maze cell merge labeller: group label tracker and stimulus.
module tb_maze_cell_merge_labeler;
  timeunit 1ns;
  timeprecision 1ps;

  import mcml_pkg::*;

  localparam int CELLS = DEF_MAX_COLUMNS * DEF_MAX_ROWS;

  // Tracks the group label of every cell and predicts one result word per input word.
  class label_tracker;
    logic [11:0] group_of [CELLS];
    bit          joined_all;
    logic [6:0]  cols_reg;
    logic [6:0]  rows_reg;
    logic [3:0]  cw_reg;
    out_t        expected_q[$];
    int          mismatches;
    int          words;
    int          status_seen[5];

    function new();
      cols_reg = GRID_COLUMNS_RST;
      rows_reg = GRID_ROWS_RST;
      cw_reg = CORRIDOR_WIDTH_RST;
      mismatches = 0;
      words = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      relabel_all();
    endfunction

    function void relabel_all();
      for (int i = 0; i < CELLS; i++) group_of[i] = 12'(i);
      joined_all = 1'b0;
    endfunction

    function int eff_cols();
      if (cols_reg < 2) return 2;
      if (cols_reg > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
      return int'(cols_reg);
    endfunction

    function int eff_rows();
      if (rows_reg < 2) return 2;
      if (rows_reg > DEF_MAX_ROWS) return DEF_MAX_ROWS;
      return int'(rows_reg);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_GRID_COLUMNS:   cols_reg = d;
        CFG_GRID_ROWS:      rows_reg = d;
        CFG_CORRIDOR_WIDTH: cw_reg = d[3:0];
        default: ;
      endcase
    endfunction

    function void note_word(in_t w);
      int cols, rows, cw, pitch, sx, sy, nx, ny, tx, ty, k, others;
      logic [11:0] cur, old;
      bit outside;
      out_t r;
      r = '0;
      cols = eff_cols();
      rows = eff_rows();
      cw = (cw_reg == 0) ? 1 : int'(cw_reg);
      pitch = cw + 1;
      others = 0;
      if (w.operation == OP_RESTART) begin
        relabel_all();
        r.status = ST_RESTARTED;
      end else if (joined_all) begin
        r.status = ST_DONE;
      end else begin
        sx = w.cell_x;
        sy = w.cell_y;
        nx = sx;
        ny = sy;
        outside = (sx >= cols) || (sy >= rows);
        case (dir_e'(w.direction))
          DIR_XP: if (sx + 1 >= cols) outside = 1'b1; else nx = sx + 1;
          DIR_XN: if (sx == 0) outside = 1'b1; else nx = sx - 1;
          DIR_YP: if (sy + 1 >= rows) outside = 1'b1; else ny = sy + 1;
          default: if (sy == 0) outside = 1'b1; else ny = sy - 1;
        endcase
        if (outside) begin
          r.status = ST_OUTSIDE;
        end else begin
          cur = group_of[sx * rows + sy];
          old = group_of[nx * rows + ny];
          if (cur == old) begin
            r.status = ST_JOINED;
          end else begin
            r.status = ST_MERGED;
            tx = 1 + sx * pitch;
            ty = 1 + sy * pitch;
            case (dir_e'(w.direction))
              DIR_XP: begin r.wall_x = 11'(tx + cw); r.wall_y = 11'(ty); r.run_along_y = 1'b1; end
              DIR_XN: begin r.wall_x = 11'(tx - 1);  r.wall_y = 11'(ty); r.run_along_y = 1'b1; end
              DIR_YP: begin r.wall_x = 11'(tx); r.wall_y = 11'(ty + cw); r.run_along_y = 1'b0; end
              default: begin r.wall_x = 11'(tx); r.wall_y = 11'(ty - 1); r.run_along_y = 1'b0; end
            endcase
            // pull the neighbour's group into the source's, count the rest
            for (int x = 0; x < cols; x++) begin
              for (int y = 0; y < rows; y++) begin
                k = x * rows + y;
                if (group_of[k] == old) group_of[k] = cur;
                else if (group_of[k] != cur) others++;
              end
            end
            r.cells_in_other_groups = 13'(others);
            if (others == 0) joined_all = 1'b1;
          end
        end
      end
      r.all_connected = joined_all;
      status_seen[int'(r.status)]++;
      words++;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with no input word pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.wall_x !== want.wall_x)
        report_mismatch($sformatf("wall_x %0d, want %0d", got.wall_x, want.wall_x));
      if (got.wall_y !== want.wall_y)
        report_mismatch($sformatf("wall_y %0d, want %0d", got.wall_y, want.wall_y));
      if (got.run_along_y !== want.run_along_y)
        report_mismatch($sformatf("run_along_y %0d, want %0d",
                                  got.run_along_y, want.run_along_y));
      if (got.cells_in_other_groups !== want.cells_in_other_groups)
        report_mismatch($sformatf("cells_in_other_groups %0d, want %0d",
                                  got.cells_in_other_groups, want.cells_in_other_groups));
      if (got.all_connected !== want.all_connected)
        report_mismatch($sformatf("all_connected %0d, want %0d",
                                  got.all_connected, want.all_connected));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_t                   in_i = '0;
  logic                  result_valid_o;
  out_t                  result_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  label_tracker tracker = new();
  bit           steady = 1'b0;

  maze_cell_merge_labeler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) tracker.check_result(result_o);
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_t mk(op_e op, int x, int y, dir_e d);
    in_t w;
    w.operation = op;
    w.cell_x = 6'(x);
    w.cell_y = 6'(y);
    w.direction = d;
    return w;
  endfunction

  function automatic in_t noise_word();
    in_t w;
    w.operation = 1'($urandom_range(0, 1));
    w.cell_x = 6'($urandom_range(0, 63));
    w.cell_y = 6'($urandom_range(0, 63));
    w.direction = 2'($urandom_range(0, 3));
    return w;
  endfunction

  // Mostly connects whose neighbour lies in the grid, so groups grow to a finished maze.
  function automatic in_t pick_word();
    in_t w;
    int c, r, roll;
    c = tracker.eff_cols();
    r = tracker.eff_rows();
    roll = $urandom_range(0, 99);
    w = mk(OP_CONNECT, $urandom_range(0, c - 1), $urandom_range(0, r - 1),
           dir_e'($urandom_range(0, 3)));
    if ((tracker.joined_all && roll < 50) || roll < 4) begin
      w.operation = OP_RESTART;
    end else if (roll < 80) begin
      case (dir_e'(w.direction))
        DIR_XP: w.cell_x = 6'($urandom_range(0, c - 2));
        DIR_XN: w.cell_x = 6'($urandom_range(1, c - 1));
        DIR_YP: w.cell_y = 6'($urandom_range(0, r - 2));
        default: w.cell_y = 6'($urandom_range(1, r - 1));
      endcase
    end else if (roll >= 90) begin
      w = noise_word();
    end
    return w;
  endfunction

  task automatic send_word(input in_t w);
    if (!steady && $urandom_range(0, 99) < 17) begin
      // idle the sender for a while; scramble the payload meanwhile
      @(negedge clk_i);
      start = 1'b0;
      in_i = noise_word();
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    in_i = w;
    do @(posedge clk_i); while (busy);
    tracker.note_word(w);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = 7'(value);
    @(posedge clk_i);
    tracker.set_reg(idx, 7'(value));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    // drop start so the last word is not taken again once the block idles
    @(negedge clk_i);
    start = 1'b0;
    while (tracker.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int c, r, n;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // full-size grid, widest corridor: edges in every direction
    write_reg(CFG_GRID_COLUMNS, 64);
    write_reg(CFG_GRID_ROWS, 64);
    write_reg(CFG_CORRIDOR_WIDTH, 15);
    send_word(mk(OP_CONNECT, 0, 0, DIR_XN));
    send_word(mk(OP_CONNECT, 0, 0, DIR_YN));
    send_word(mk(OP_CONNECT, 63, 63, DIR_XP));
    send_word(mk(OP_CONNECT, 63, 63, DIR_YP));
    send_word(mk(OP_CONNECT, 63, 63, DIR_XN));
    send_word(mk(OP_CONNECT, 63, 63, DIR_YN));
    send_word(mk(OP_CONNECT, 62, 63, DIR_XP));
    send_word(mk(OP_CONNECT, 0, 0, DIR_XP));
    send_word(mk(OP_CONNECT, 0, 0, DIR_YP));

    // shrink without restarting: old labels read with the new indexing
    settle();
    write_reg(CFG_GRID_COLUMNS, 2);
    write_reg(CFG_GRID_ROWS, 2);
    write_reg(CFG_CORRIDOR_WIDTH, 0);
    send_word(mk(OP_CONNECT, 2, 0, DIR_XN));
    send_word(mk(OP_CONNECT, 0, 3, DIR_YN));
    send_word(mk(OP_CONNECT, 0, 0, DIR_XP));
    send_word(mk(OP_CONNECT, 0, 1, DIR_XP));
    send_word(mk(OP_CONNECT, 1, 0, DIR_YP));
    send_word(mk(OP_CONNECT, 0, 0, DIR_YP));
    send_word(mk(OP_CONNECT, 1, 1, DIR_YN));
    send_word(mk(OP_RESTART, 63, 63, DIR_YN));
    send_word(mk(OP_CONNECT, 1, 1, DIR_XN));

    // saturating register values and the spare index
    settle();
    write_reg(CFG_GRID_COLUMNS, 0);
    write_reg(CFG_GRID_ROWS, 127);
    write_reg(CFG_CORRIDOR_WIDTH, 127);
    write_reg(CFG_UNUSED, 'h55);
    send_word(mk(OP_CONNECT, 1, 63, DIR_XN));
    send_word(mk(OP_CONNECT, 1, 63, DIR_YP));
    send_word(mk(OP_CONNECT, 0, 0, DIR_YN));

    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin c = 64; r = 64; end
        3: begin c = 127; r = 1; end
        5: begin c = 0; r = $urandom_range(2, 5); end
        default: begin c = $urandom_range(2, 5); r = $urandom_range(2, 5); end
      endcase
      write_reg(CFG_GRID_COLUMNS, c);
      write_reg(CFG_GRID_ROWS, r);
      write_reg(CFG_CORRIDOR_WIDTH, $urandom_range(0, 127));
      steady = (ph == 2);
      n = (ph == 0) ? 8 : 18;
      if (tracker.joined_all || $urandom_range(0, 1) == 1)
        send_word(mk(OP_RESTART, $urandom_range(0, 63), $urandom_range(0, 63), DIR_XP));
      repeat (n) send_word(pick_word());
    end

    @(negedge clk_i);
    start = 1'b0;
    settle();
    repeat (16) @(posedge clk_i);
    if (tracker.expected_q.size() != 0)
      tracker.report_mismatch($sformatf("%0d result words never arrived",
                                        tracker.expected_q.size()));
    $display("Run covered %0d words: %0d merged, %0d outside, %0d joined, %0d done, %0d restarts",
             tracker.words, tracker.status_seen[ST_MERGED], tracker.status_seen[ST_OUTSIDE],
             tracker.status_seen[ST_JOINED], tracker.status_seen[ST_DONE],
             tracker.status_seen[ST_RESTARTED]);
    $display("Grids from 2x2 to 64x64, corridor widths 0..15, %0d mismatches",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
